// ===== src/ftq_pkg.sv =====
package ftq_pkg;
  localparam int NUM_RINGS = 4;
  localparam int QUEUE_DEPTH = 16;
  localparam int MAX_RESULTS = 16;
  localparam int RW = (NUM_RINGS > 1) ? $clog2(NUM_RINGS) : 1;
  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int AW = RW + PW;
  localparam int NW = $clog2(MAX_RESULTS + 1);

  localparam logic [1:0] OP_TASK = 2'd0;
  localparam logic [1:0] OP_FENCE = 2'd1;
  localparam logic [1:0] OP_NOTIFY = 2'd2;

  localparam logic [1:0] KIND_TASK = 2'd0;
  localparam logic [1:0] KIND_FENCE = 2'd1;
  localparam logic [1:0] KIND_DONE = 2'd2;
  localparam logic [1:0] KIND_ERROR = 2'd3;

  localparam logic [2:0] ERR_NONE = 3'd0;
  localparam logic [2:0] ERR_UNKNOWN = 3'd1;
  localparam logic [2:0] ERR_COMPLETED = 3'd2;
  localparam logic [2:0] ERR_FULL = 3'd3;
  localparam logic [2:0] ERR_RING = 3'd4;

  typedef struct packed {
    logic [63:0] payload;
    logic        is_fence;
    logic        done;
  } slot_t;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [1:0]  ring_index;
    logic [63:0] fence_id;
    logic [31:0] task_id;
  } in_beat_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [1:0]  ring_out;
    logic [63:0] signalled_fence;
    logic [31:0] assigned_task_id;
    logic [2:0]  error_code;
    logic        last;
  } out_beat_t;
endpackage

// ===== src/ftq_if.sv =====
interface ftq_in_if;
  import ftq_pkg::*;
  logic valid;
  logic ready;
  logic [1:0] opcode;
  logic [1:0] ring_index;
  logic [63:0] fence_id;
  logic [31:0] task_id;
  modport source(output valid, opcode, ring_index, fence_id, task_id, input ready);
  modport sink(input valid, opcode, ring_index, fence_id, task_id, output ready);
endinterface

interface ftq_out_if;
  logic valid;
  logic ready;
  logic [1:0] kind;
  logic [1:0] ring_out;
  logic [63:0] signalled_fence;
  logic [31:0] assigned_task_id;
  logic [2:0] error_code;
  logic last;
  modport source(output valid, kind, ring_out, signalled_fence, assigned_task_id,
    error_code, last, input ready);
  modport sink(input valid, kind, ring_out, signalled_fence, assigned_task_id,
    error_code, last, output ready);
endinterface

// ===== src/ftq_mem.sv =====
module ftq_mem (
  input  logic              clk,
  input  logic              we,
  input  logic [ftq_pkg::AW-1:0] waddr,
  input  ftq_pkg::slot_t    wdata,
  input  logic [ftq_pkg::AW-1:0] raddr,
  output ftq_pkg::slot_t    rdata
);
  import ftq_pkg::*;
  slot_t mem [NUM_RINGS*QUEUE_DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ===== src/fence_timeline_queue.sv =====
// Fence timeline queue: one FIFO of tasks and fences per ring in a shared
// single-port-read entry memory. One input beat at a time; ready is low while
// it is processed. Fence enqueue and task completion walk the memory one entry
// read at a time: a drain starts once the entry write has landed and drops
// entries from the head, and each result beat waits for the output to be
// taken. No clearing pass.
module fence_timeline_queue (
  input logic clk,
  input logic rst,
  ftq_in_if.sink   in,
  ftq_out_if.source out
);
  import ftq_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001, S_DEC = 7'b0000010, S_SRD = 7'b0000100,
    S_SCHK = 7'b0001000, S_DRD = 7'b0010000, S_DCHK = 7'b0100000,
    S_OUT = 7'b1000000
  } state_t;

  state_t state;
  in_beat_t cur;
  logic [PW-1:0] head [NUM_RINGS];
  logic [CW-1:0] count [NUM_RINGS];
  logic [31:0] next_tid;
  logic [RW-1:0] ring;
  logic [CW-1:0] k;
  logic seen, final_out;
  logic [NW-1:0] n;
  out_beat_t ob;
  out_beat_t ob_pending;

  logic we;
  logic [AW-1:0] waddr, raddr;
  slot_t wdata, rdata;
  logic [PW-1:0] pos;
  ftq_mem u_mem (.clk, .we, .waddr, .wdata, .raddr, .rdata);

  assign pos = head[ring] + k[PW-1:0];
  assign raddr = {ring, pos};

  assign in.ready = (state == S_IDLE);
  assign out.valid = (state == S_OUT);
  assign out.kind = ob.kind;
  assign out.ring_out = ob.ring_out;
  assign out.signalled_fence = ob.signalled_fence;
  assign out.assigned_task_id = ob.assigned_task_id;
  assign out.error_code = ob.error_code;
  assign out.last = ob.last;

  function automatic out_beat_t mk(logic [1:0] kd, logic [1:0] r, logic [63:0] f,
                                   logic [31:0] t, logic [2:0] e, logic l);
    out_beat_t o;
    o.kind = kd; o.ring_out = r; o.signalled_fence = f;
    o.assigned_task_id = t; o.error_code = e; o.last = l;
    return o;
  endfunction

  always_ff @(posedge clk) begin
    we <= 1'b0;
    if (rst) begin
      state <= S_IDLE;
      next_tid <= '0;
      for (int i = 0; i < NUM_RINGS; i++) begin
        head[i] <= '0;
        count[i] <= '0;
      end
    end else begin
      case (state)
        S_IDLE: if (in.valid) begin
          cur <= '{in.opcode, in.ring_index, in.fence_id, in.task_id};
          ring <= in.ring_index[RW-1:0];
          k <= '0; seen <= 1'b0; n <= '0;
          state <= S_DEC;
        end
        S_DEC: begin
          final_out <= 1'b1;
          state <= S_OUT;
          if (cur.opcode == OP_TASK || cur.opcode == OP_FENCE) begin
            if (!({6'd0, cur.ring_index} < 8'(NUM_RINGS)))
              ob <= mk(KIND_ERROR, cur.ring_index, '0, '0, ERR_RING, 1'b1);
            else if (count[ring] >= CW'(QUEUE_DEPTH))
              ob <= mk(KIND_ERROR, cur.ring_index, '0, '0, ERR_FULL, 1'b1);
            else begin
              we <= 1'b1;
              waddr <= {ring, head[ring] + count[ring][PW-1:0]};
              count[ring] <= count[ring] + 1'b1;
              if (cur.opcode == OP_TASK) begin
                wdata <= '{{32'd0, next_tid}, 1'b0, 1'b0};
                next_tid <= next_tid + 1'b1;
                ob <= mk(KIND_TASK, cur.ring_index, '0, next_tid, ERR_NONE, 1'b1);
              end else begin
                wdata <= '{cur.fence_id, 1'b1, 1'b0};
                k <= '0;
                state <= S_DRD;
              end
            end
          end else if (cur.opcode == OP_NOTIFY) begin
            ring <= '0; k <= '0;
            state <= S_SRD;
          end else
            ob <= mk(KIND_DONE, cur.ring_index, '0, '0, ERR_NONE, 1'b1);
        end
        S_SRD: begin
          if (k >= count[ring]) begin
            if (32'(ring) == 32'(NUM_RINGS - 1)) begin
              ob <= mk(KIND_ERROR, 2'd0, '0, '0, seen ? ERR_COMPLETED : ERR_UNKNOWN,
                       1'b1);
              final_out <= 1'b1;
              state <= S_OUT;
            end else begin
              ring <= ring + 1'b1; k <= '0;
            end
          end else state <= S_SCHK;
        end
        S_SCHK: begin
          if (!rdata.is_fence && rdata.payload == {32'd0, cur.task_id}) begin
            if (rdata.done) begin
              seen <= 1'b1; k <= k + 1'b1; state <= S_SRD;
            end else begin
              we <= 1'b1; waddr <= raddr; wdata <= '{rdata.payload, 1'b0, 1'b1};
              k <= '0; state <= S_DRD;
            end
          end else begin
            k <= k + 1'b1; state <= S_SRD;
          end
        end
        S_DRD: begin
          // let a pending entry write land before the head is read
          if (we) state <= S_DRD;
          else state <= S_DCHK;
        end
        S_DCHK: begin
          if (count[ring] == '0 || (rdata.is_fence && n >= NW'(MAX_RESULTS)) ||
              (!rdata.is_fence && !rdata.done)) begin
            if (n == '0) begin
              ob <= mk(KIND_DONE, 2'(ring), '0, '0, ERR_NONE, 1'b1);
              final_out <= 1'b1;
              state <= S_OUT;
            end else begin
              ob.last <= 1'b1; final_out <= 1'b1; state <= S_OUT;
            end
          end else begin
            head[ring] <= head[ring] + 1'b1;
            count[ring] <= count[ring] - 1'b1;
            if (rdata.is_fence) begin
              if (n != '0) begin
                final_out <= 1'b0;
                state <= S_OUT;
              end else state <= S_DRD;
              if (n == '0) ob <= mk(KIND_FENCE, 2'(ring), rdata.payload, '0,
                                    ERR_NONE, 1'b0);
              else ob_pending <= mk(KIND_FENCE, 2'(ring), rdata.payload, '0,
                                    ERR_NONE, 1'b0);
              n <= n + 1'b1;
            end else state <= S_DRD;
          end
        end
        S_OUT: if (out.ready) begin
          if (final_out) state <= S_IDLE;
          else begin
            ob <= ob_pending;
            state <= S_DRD;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
